// ----- design/jerk_limited_speed_profile_macros.svh -----
// ----------------------------------------------------------------------------
// jerk_limited_speed_profile assertion macros
// Shared concurrent assertion shorthands for the speed profile checkers.
// ----------------------------------------------------------------------------
`ifndef JERK_LIMITED_SPEED_PROFILE_MACROS_SVH
`define JERK_LIMITED_SPEED_PROFILE_MACROS_SVH

// same-cycle implication
`define JLSP_ASSERT_IMP(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("jlsp assertion failed");

// next-cycle implication
`define JLSP_ASSERT_NXT(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("jlsp assertion failed");

`endif

// ----- design/jlsp_pkg.sv -----
// ----------------------------------------------------------------------------
// jlsp_pkg
// Widths, register reset values and indexes, and sequencer states of the speed profile block.
// ----------------------------------------------------------------------------
package jlsp_pkg;

	localparam int FIELD_W = 24;
	localparam int SPEED_W = 25;
	localparam int TOTAL_W = 32;
	localparam int CFG_W   = 24;
	localparam int JERK_W  = 24;
	localparam int ALIM_W  = 23;
	localparam int DT_W    = 16;
	localparam int TOL_W   = 16;
	localparam int CMP_W   = 27;
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 25;
	localparam int PROD_W  = 51;
	localparam int JDT_W   = 40;
	localparam int SQ_X_W  = 50;
	localparam int ROOT_W  = 25;
	localparam int ACC_W   = 42;

	localparam logic [JERK_W-1:0] JERK_RST = JERK_W'(655360);
	localparam logic [ALIM_W-1:0] ALIM_RST = ALIM_W'(655360);
	localparam logic [DT_W-1:0]   DT_RST   = DT_W'(1311);
	localparam logic [TOL_W-1:0]  TOL_RST  = TOL_W'(6554);

	typedef enum logic [1:0] {
		REG_JERK_LIMIT  = 2'd0,
		REG_ACCEL_LIMIT = 2'd1,
		REG_STEP_TIME   = 2'd2,
		REG_SPEED_TOL   = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_JDT,
		ST_CHECK,
		ST_ROOT_MUL,
		ST_ROOT_START,
		ST_ROOT_WAIT,
		ST_CLAMP1,
		ST_CLAMP2,
		ST_ACC_MUL,
		ST_SPD,
		ST_DIST_MUL,
		ST_DIST,
		ST_EMIT
	} state_t;

endpackage

// ----- design/jlsp_in_if.sv -----
// ----------------------------------------------------------------------------
// jlsp_in_if
// Input channel: start speed, start acceleration and target speed.
// ----------------------------------------------------------------------------
interface jlsp_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [jlsp_pkg::FIELD_W-1:0] start_speed;
	logic signed [jlsp_pkg::FIELD_W-1:0] start_accel;
	logic signed [jlsp_pkg::FIELD_W-1:0] target_speed;

	modport source (output valid, output start_speed, output start_accel,
		output target_speed, input ready);
	modport sink (input valid, input start_speed, input start_accel,
		input target_speed, output ready);
endinterface

// ----- design/jlsp_out_if.sv -----
// ----------------------------------------------------------------------------
// jlsp_out_if
// Output channel: one profile step per transfer.
// ----------------------------------------------------------------------------
interface jlsp_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [jlsp_pkg::FIELD_W-1:0] step_distance;
	logic signed [jlsp_pkg::FIELD_W-1:0] step_speed;
	logic signed [jlsp_pkg::TOTAL_W-1:0] total_distance;
	logic                                last;
	logic                                empty_res;
	logic                                truncated;

	modport source (output valid, output step_distance, output step_speed,
		output total_distance, output last, output empty_res, output truncated,
		input ready);
	modport sink (input valid, input step_distance, input step_speed,
		input total_distance, input last, input empty_res, input truncated,
		output ready);
endinterface

// ----- design/jerk_limited_speed_profile.sv -----
// ----------------------------------------------------------------------------
// jerk_limited_speed_profile
// Jerk-limited S-curve speed profile, one step result per output transfer.
// ----------------------------------------------------------------------------
// One input item is taken at a time. After setup, each step uses the
// bit-serial square root, three passes through the single shared multiplier
// and the clamp and update stages, and can be held by an output stall. A run
// ends after at most MAX_STEPS = 64 steps. The input is ready only while the
// sequencer is idle.
module jerk_limited_speed_profile #(
	parameter int MAX_STEPS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [jlsp_pkg::CFG_W-1:0]    cfg_data,
	jlsp_in_if.sink                       in_ch,
	jlsp_out_if.source                    out_ch
);

	localparam int CW     = $clog2(MAX_STEPS + 1);
	localparam int FW     = jlsp_pkg::FIELD_W;
	localparam int VW     = jlsp_pkg::SPEED_W;
	localparam int TW     = jlsp_pkg::TOTAL_W;
	localparam int PW     = jlsp_pkg::PROD_W;
	localparam int AW     = jlsp_pkg::ACC_W;
	localparam int KW     = jlsp_pkg::CMP_W;

	localparam logic signed [PW:0]   SPD_MAX = (PW+1)'(2**(VW-1) - 1);
	localparam logic signed [PW:0]   SPD_MIN = -SPD_MAX - (PW+1)'(1);
	localparam logic signed [PW-1:0] FLD_MAX = PW'(2**(FW-1) - 1);
	localparam logic signed [PW-1:0] FLD_MIN = -FLD_MAX - PW'(1);
	localparam logic signed [TW:0]   TOT_MAX = (TW+1)'(33'sh0_7FFF_FFFF);
	localparam logic signed [TW:0]   TOT_MIN = -TOT_MAX - (TW+1)'(1);

	jlsp_pkg::state_t state_q, state_d;

	logic [jlsp_pkg::JERK_W-1:0] jerk_q;
	logic [jlsp_pkg::ALIM_W-1:0] alim_q;
	logic [jlsp_pkg::DT_W-1:0]   dt_q;
	logic [jlsp_pkg::TOL_W-1:0]  tol_q;

	logic signed [VW-1:0] speed_q;
	logic signed [VW-1:0] accel_q;
	logic signed [FW-1:0] target_q;
	logic                 rising_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_nx;
	logic [AW-1:0]        jstep_q;
	logic [AW-1:0]        half_q;
	logic signed [AW-1:0] aim_q;
	logic signed [AW-1:0] hi_q;
	logic signed [AW-1:0] lo_q;
	logic signed [FW-1:0] dist_q;
	logic signed [FW-1:0] spdo_q;
	logic signed [TW-1:0] sum_q;
	logic                 last_q;
	logic                 empty_q;
	logic                 trunc_q;

	logic signed [jlsp_pkg::MUL_A_W-1:0] mul_a;
	logic signed [jlsp_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]                mul_p;
	logic                                sq_start;
	logic                                sq_busy;
	logic [jlsp_pkg::ROOT_W-1:0]         sq_root;
	logic [jlsp_pkg::SQ_X_W-1:0]         sq_x;

	logic signed [KW-1:0] spd_k;
	logic signed [KW-1:0] tgt_k;
	logic signed [KW-1:0] tol_k;
	logic signed [KW-1:0] rem;
	logic signed [KW-1:0] mag;
	logic                 rem_pos;
	logic                 outside;

	logic signed [AW-1:0] acc_s;
	logic signed [AW-1:0] root_s;
	logic signed [AW-1:0] alim_s;
	logic signed [AW-1:0] hi_raw;
	logic signed [AW-1:0] lo_raw;
	logic signed [AW-1:0] aim_raw;
	logic signed [AW-1:0] aim_hi;
	logic signed [AW-1:0] aim_fin;

	logic signed [PW-1:0] shifted;
	logic signed [PW:0]   spd_sum;
	logic signed [VW-1:0] spd_sat;
	logic signed [FW-1:0] dist_sat;
	logic signed [FW-1:0] spdo_sat;
	logic signed [TW:0]   tot_sum;
	logic signed [TW-1:0] tot_sat;

	jlsp_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (mul_p)
	);

	assign sq_x = {mul_p[jlsp_pkg::SQ_X_W-2:0], 1'b0};

	jlsp_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.x      (sq_x),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// band test and remaining change
	assign spd_k   = KW'(speed_q);
	assign tgt_k   = KW'(target_q);
	assign tol_k   = $signed(KW'(tol_q));
	assign rem     = tgt_k - spd_k;
	assign mag     = rem[KW-1] ? -rem : rem;
	assign rem_pos = !rem[KW-1] && (rem != '0);
	assign outside = rising_q ? (spd_k < tgt_k - tol_k) : (spd_k > tgt_k + tol_k);
	assign cnt_nx  = cnt_q + CW'(1);

	// clamp window
	assign acc_s   = AW'(accel_q);
	assign root_s  = $signed(AW'(sq_root));
	assign alim_s  = $signed(AW'(alim_q));
	assign hi_raw  = acc_s + $signed(jstep_q);
	assign lo_raw  = acc_s - $signed(jstep_q);
	assign aim_raw = rem_pos ? root_s - $signed(half_q) : $signed(half_q) - root_s;
	assign aim_hi  = (aim_q > hi_q) ? hi_q : aim_q;
	assign aim_fin = (aim_hi < lo_q) ? lo_q : aim_hi;

	// speed and distance updates
	assign shifted = mul_p >>> FRAC_BITS;
	assign spd_sum = (PW+1)'(speed_q) + (PW+1)'(shifted);

	always_comb begin
		if (spd_sum > SPD_MAX) begin
			spd_sat = VW'(SPD_MAX);
		end else if (spd_sum < SPD_MIN) begin
			spd_sat = VW'(SPD_MIN);
		end else begin
			spd_sat = VW'(spd_sum);
		end
	end

	always_comb begin
		if (shifted > FLD_MAX) begin
			dist_sat = FW'(FLD_MAX);
		end else if (shifted < FLD_MIN) begin
			dist_sat = FW'(FLD_MIN);
		end else begin
			dist_sat = FW'(shifted);
		end
	end

	always_comb begin
		if (speed_q > VW'(FLD_MAX)) begin
			spdo_sat = FW'(FLD_MAX);
		end else if (speed_q < VW'(FLD_MIN)) begin
			spdo_sat = FW'(FLD_MIN);
		end else begin
			spdo_sat = FW'(speed_q);
		end
	end

	assign tot_sum = (TW+1)'(sum_q) + (TW+1)'(dist_sat);

	always_comb begin
		if (tot_sum > TOT_MAX) begin
			tot_sat = TW'(TOT_MAX);
		end else if (tot_sum < TOT_MIN) begin
			tot_sat = TW'(TOT_MIN);
		end else begin
			tot_sat = TW'(tot_sum);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			jlsp_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					state_d = jlsp_pkg::ST_JDT;
				end
			end
			jlsp_pkg::ST_JDT:        state_d = jlsp_pkg::ST_CHECK;
			jlsp_pkg::ST_CHECK: begin
				state_d = outside ? jlsp_pkg::ST_ROOT_MUL : jlsp_pkg::ST_EMIT;
			end
			jlsp_pkg::ST_ROOT_MUL:   state_d = jlsp_pkg::ST_ROOT_START;
			jlsp_pkg::ST_ROOT_START: state_d = jlsp_pkg::ST_ROOT_WAIT;
			jlsp_pkg::ST_ROOT_WAIT: begin
				if (!sq_busy) begin
					state_d = jlsp_pkg::ST_CLAMP1;
				end
			end
			jlsp_pkg::ST_CLAMP1:     state_d = jlsp_pkg::ST_CLAMP2;
			jlsp_pkg::ST_CLAMP2:     state_d = jlsp_pkg::ST_ACC_MUL;
			jlsp_pkg::ST_ACC_MUL:    state_d = jlsp_pkg::ST_SPD;
			jlsp_pkg::ST_SPD:        state_d = jlsp_pkg::ST_DIST_MUL;
			jlsp_pkg::ST_DIST_MUL:   state_d = jlsp_pkg::ST_DIST;
			jlsp_pkg::ST_DIST:       state_d = jlsp_pkg::ST_EMIT;
			jlsp_pkg::ST_EMIT: begin
				if (out_ch.ready) begin
					state_d = last_q ? jlsp_pkg::ST_IDLE : jlsp_pkg::ST_ROOT_MUL;
				end
			end
			default:                 state_d = jlsp_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		sq_start = 1'b0;
		case (state_q)
			jlsp_pkg::ST_JDT: begin
				mul_a = jlsp_pkg::MUL_A_W'(dt_q);
				mul_b = jlsp_pkg::MUL_B_W'(jerk_q);
			end
			jlsp_pkg::ST_ROOT_MUL: begin
				mul_a = jlsp_pkg::MUL_A_W'(mag);
				mul_b = jlsp_pkg::MUL_B_W'(jerk_q);
			end
			jlsp_pkg::ST_ROOT_START: begin
				sq_start = 1'b1;
			end
			jlsp_pkg::ST_ACC_MUL: begin
				mul_a = jlsp_pkg::MUL_A_W'(accel_q);
				mul_b = jlsp_pkg::MUL_B_W'(dt_q);
			end
			jlsp_pkg::ST_DIST_MUL: begin
				mul_a = jlsp_pkg::MUL_A_W'(speed_q);
				mul_b = jlsp_pkg::MUL_B_W'(dt_q);
			end
			default: begin
				sq_start = 1'b0;
			end
		endcase
	end

	assign in_ch.ready           = (state_q == jlsp_pkg::ST_IDLE);
	assign out_ch.valid          = (state_q == jlsp_pkg::ST_EMIT);
	assign out_ch.step_distance  = dist_q;
	assign out_ch.step_speed     = spdo_q;
	assign out_ch.total_distance = sum_q;
	assign out_ch.last           = last_q;
	assign out_ch.empty_res      = empty_q;
	assign out_ch.truncated      = trunc_q;

	// control state and registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jlsp_pkg::ST_IDLE;
			cnt_q   <= '0;
			jerk_q  <= jlsp_pkg::JERK_RST;
			alim_q  <= jlsp_pkg::ALIM_RST;
			dt_q    <= jlsp_pkg::DT_RST;
			tol_q   <= jlsp_pkg::TOL_RST;
		end else begin
			state_q <= state_d;
			if (state_q == jlsp_pkg::ST_IDLE && in_ch.valid) begin
				cnt_q <= '0;
			end else if (state_q == jlsp_pkg::ST_DIST) begin
				cnt_q <= cnt_nx;
			end
			if (cfg_we) begin
				case (jlsp_pkg::reg_idx_t'(cfg_index))
					jlsp_pkg::REG_JERK_LIMIT:  jerk_q <= cfg_data[jlsp_pkg::JERK_W-1:0];
					jlsp_pkg::REG_ACCEL_LIMIT: alim_q <= cfg_data[jlsp_pkg::ALIM_W-1:0];
					jlsp_pkg::REG_STEP_TIME:   dt_q   <= cfg_data[jlsp_pkg::DT_W-1:0];
					jlsp_pkg::REG_SPEED_TOL:   tol_q  <= cfg_data[jlsp_pkg::TOL_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			jlsp_pkg::ST_IDLE: begin
				if (in_ch.valid) begin
					speed_q  <= VW'(in_ch.start_speed);
					accel_q  <= VW'(in_ch.start_accel);
					target_q <= in_ch.target_speed;
					rising_q <= in_ch.start_speed < in_ch.target_speed;
					sum_q    <= '0;
				end
			end
			jlsp_pkg::ST_CHECK: begin
				jstep_q <= AW'(mul_p[jlsp_pkg::JDT_W-1:0] >> FRAC_BITS);
				half_q  <= AW'(mul_p[jlsp_pkg::JDT_W-1:0] >> (FRAC_BITS + 1));
				if (!outside) begin
					dist_q  <= '0;
					spdo_q  <= '0;
					sum_q   <= '0;
					last_q  <= 1'b1;
					empty_q <= 1'b1;
					trunc_q <= 1'b0;
				end
			end
			jlsp_pkg::ST_CLAMP1: begin
				aim_q <= aim_raw;
				hi_q  <= (hi_raw > alim_s) ? alim_s : hi_raw;
				lo_q  <= (lo_raw < -alim_s) ? -alim_s : lo_raw;
			end
			jlsp_pkg::ST_CLAMP2: begin
				accel_q <= VW'(aim_fin);
			end
			jlsp_pkg::ST_SPD: begin
				speed_q <= spd_sat;
			end
			jlsp_pkg::ST_DIST: begin
				dist_q  <= dist_sat;
				spdo_q  <= spdo_sat;
				sum_q   <= tot_sat;
				empty_q <= 1'b0;
				last_q  <= (cnt_nx == CW'(MAX_STEPS)) || !outside;
				trunc_q <= (cnt_nx == CW'(MAX_STEPS)) && outside;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- design/jlsp_mul.sv -----
// ----------------------------------------------------------------------------
// jlsp_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module jlsp_mul (
	input  logic                                clk,
	input  logic signed [jlsp_pkg::MUL_A_W-1:0] a,
	input  logic signed [jlsp_pkg::MUL_B_W-1:0] b,
	output logic signed [jlsp_pkg::PROD_W-1:0]  prod
);

	logic signed [jlsp_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= jlsp_pkg::PROD_W'(a) * jlsp_pkg::PROD_W'(b);
	end

	assign prod = prod_q;

endmodule

// ----- design/jlsp_isqrt.sv -----
// ----------------------------------------------------------------------------
// jlsp_isqrt
// Integer square root, one result bit per cycle (floor).
// ----------------------------------------------------------------------------
module jlsp_isqrt (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [jlsp_pkg::SQ_X_W-1:0]        x,
	output logic                               busy,
	output logic [jlsp_pkg::ROOT_W-1:0]        root
);

	localparam int XW = jlsp_pkg::SQ_X_W;

	logic          busy_q;
	logic [XW-1:0] x_q;
	logic [XW-1:0] r_q;
	logic [XW-2:0] bit_q;
	logic [XW:0]   trial;
	logic          take;

	assign trial = (XW+1)'(r_q) + (XW+1)'(bit_q);
	assign take  = (XW+1)'(x_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			r_q   <= '0;
			bit_q <= {1'b1, {(XW-2){1'b0}}};
		end else if (busy_q) begin
			if (take) begin
				x_q <= XW'((XW+1)'(x_q) - trial);
				r_q <= (r_q >> 1) + XW'(bit_q);
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = r_q[jlsp_pkg::ROOT_W-1:0];

endmodule

// ----- design/jlsp_checker.sv -----
// ----------------------------------------------------------------------------
// jlsp_checker
// Port-level checks of the speed profile block, bound to the top level.
// ----------------------------------------------------------------------------
`include "jerk_limited_speed_profile_macros.svh"

module jlsp_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [jlsp_pkg::FIELD_W-1:0] step_distance,
	input logic signed [jlsp_pkg::FIELD_W-1:0] step_speed,
	input logic signed [jlsp_pkg::TOTAL_W-1:0] total_distance,
	input logic                                last,
	input logic                                empty_res,
	input logic                                truncated
);

	`JLSP_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`JLSP_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(step_distance) && $stable(step_speed) && $stable(total_distance) && $stable(last))
	`JLSP_ASSERT_IMP(a_one_item, clk, arst_n, in_ready, !out_valid)
	`JLSP_ASSERT_IMP(a_empty_zero, clk, arst_n, out_valid && empty_res, last && !truncated && step_distance == '0 && step_speed == '0 && total_distance == '0)
	`JLSP_ASSERT_IMP(a_trunc_last, clk, arst_n, out_valid && truncated, last && !empty_res)

endmodule

bind jerk_limited_speed_profile jlsp_checker u_jlsp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.step_distance  (out_ch.step_distance),
	.step_speed     (out_ch.step_speed),
	.total_distance (out_ch.total_distance),
	.last           (out_ch.last),
	.empty_res      (out_ch.empty_res),
	.truncated      (out_ch.truncated)
);

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the jerk-limited speed profile. Speed profile
// requests go in over the input channel and every step result is checked
// against a bit-exact profile predictor kept in the bench. The run covers
// reset register values, the special cases, register extremes and random
// requests under three sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int     PROFILE_STEPS = 64;
	localparam int     FRAC          = 16;
	localparam longint ONE           = 64'sd65536;
	localparam longint RUN_LIMIT     = 64'd50_000_000;

	typedef struct {
		logic signed [jlsp_pkg::FIELD_W-1:0] step_distance;
		logic signed [jlsp_pkg::FIELD_W-1:0] step_speed;
		logic signed [jlsp_pkg::TOTAL_W-1:0] total_distance;
		logic                                last;
		logic                                empty_res;
		logic                                truncated;
	} profile_step_t;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [1:0]                   cfg_index;
	logic [jlsp_pkg::CFG_W-1:0]   cfg_data;

	jlsp_in_if  in_ch ();
	jlsp_out_if out_ch ();

	jerk_limited_speed_profile #(
		.MAX_STEPS (PROFILE_STEPS),
		.FRAC_BITS (FRAC)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// register copies for the predictor
	logic [jlsp_pkg::JERK_W-1:0] jerk_reg;
	logic [jlsp_pkg::ALIM_W-1:0] alim_reg;
	logic [jlsp_pkg::DT_W-1:0]   dt_reg;
	logic [jlsp_pkg::TOL_W-1:0]  tol_reg;

	profile_step_t expected_steps[$];
	int            error_count;
	int            src_idle_pct;
	int            sink_idle_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(RUN_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	function automatic longint clip(longint v, int w);
		longint top;
		top = (longint'(1) << (w - 1)) - 1;
		if (v > top)
			return top;
		if (v < -top - 1)
			return -top - 1;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic bit off_target(longint spd, longint tgt, longint tol, bit rising);
		return rising ? (spd < tgt - tol) : (spd > tgt + tol);
	endfunction

	task automatic predict_profile(input logic signed [jlsp_pkg::FIELD_W-1:0] s0, a0, tgt_in);
		longint          tgt, tol, jdt, jstep, half, alim, dt;
		longint          spd, acc, sum, rem, aim, hi, lo, step_dist;
		longint unsigned root;
		bit              rising, more;
		int              n;
		profile_step_t   st;
		tgt   = longint'(tgt_in);
		tol   = longint'(tol_reg);
		jdt   = longint'(jerk_reg) * longint'(dt_reg);
		jstep = jdt >>> FRAC;
		half  = jdt >>> (FRAC + 1);
		alim  = longint'(alim_reg);
		dt    = longint'(dt_reg);
		spd   = longint'(s0);
		acc   = longint'(a0);
		sum   = 0;
		n     = 0;
		rising = spd < tgt;
		st.step_distance  = '0;
		st.step_speed     = '0;
		st.total_distance = '0;
		st.truncated      = 1'b0;
		if (!off_target(spd, tgt, tol, rising)) begin
			st.last      = 1'b1;
			st.empty_res = 1'b1;
			expected_steps = {expected_steps, st};
		end else begin
			more = 1'b1;
			while (more) begin
				rem  = tgt - spd;
				root = int_sqrt(64'd2 * jerk_reg * longint'(rem < 0 ? -rem : rem));
				aim  = rem > 0 ? longint'(root) - half : half - longint'(root);
				hi   = acc + jstep;
				lo   = acc - jstep;
				if (hi > alim)
					hi = alim;
				if (lo < -alim)
					lo = -alim;
				if (aim > hi)
					aim = hi;
				if (aim < lo)
					aim = lo;
				acc       = aim;
				spd       = clip(spd + ((acc * dt) >>> FRAC), jlsp_pkg::SPEED_W);
				step_dist = clip((spd * dt) >>> FRAC, jlsp_pkg::FIELD_W);
				sum       = clip(sum + step_dist, jlsp_pkg::TOTAL_W);
				n++;
				more = (n < PROFILE_STEPS) && off_target(spd, tgt, tol, rising);
				st.step_distance  = jlsp_pkg::FIELD_W'(step_dist);
				st.step_speed     = jlsp_pkg::FIELD_W'(clip(spd, jlsp_pkg::FIELD_W));
				st.total_distance = jlsp_pkg::TOTAL_W'(sum);
				st.last           = !more;
				st.empty_res      = 1'b0;
				st.truncated      = !more && off_target(spd, tgt, tol, rising);
				expected_steps = {expected_steps, st};
			end
		end
	endtask

	// valid stays high after a transfer; an idle gap before the next request or the drain lowers it
	task automatic send_request(input logic signed [jlsp_pkg::FIELD_W-1:0] s0, a0, tgt);
		if ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		in_ch.valid        <= 1'b1;
		in_ch.start_speed  <= s0;
		in_ch.start_accel  <= a0;
		in_ch.target_speed <= tgt;
		do
			@(posedge clk);
		while (!in_ch.ready);
		predict_profile(s0, a0, tgt);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		while (expected_steps.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_registers(input logic [jlsp_pkg::CFG_W-1:0] jerk, accel, dt, tol);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= jlsp_pkg::REG_JERK_LIMIT;
		cfg_data  <= jerk;
		@(posedge clk);
		cfg_index <= jlsp_pkg::REG_ACCEL_LIMIT;
		cfg_data  <= accel;
		@(posedge clk);
		cfg_index <= jlsp_pkg::REG_STEP_TIME;
		cfg_data  <= dt;
		@(posedge clk);
		cfg_index <= jlsp_pkg::REG_SPEED_TOL;
		cfg_data  <= tol;
		@(posedge clk);
		cfg_we   <= 1'b0;
		jerk_reg = jerk[jlsp_pkg::JERK_W-1:0];
		alim_reg = accel[jlsp_pkg::ALIM_W-1:0];
		dt_reg   = dt[jlsp_pkg::DT_W-1:0];
		tol_reg  = tol[jlsp_pkg::TOL_W-1:0];
	endtask

	task automatic check_field(input string name, input longint want, got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		profile_step_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_steps.size() == 0) begin
				$display("%0t: step_speed expected no result actual %0d", $time,
					out_ch.step_speed);
				error_count++;
			end else begin
				want = expected_steps.pop_front();
				check_field("step_distance", longint'(want.step_distance),
					longint'(out_ch.step_distance));
				check_field("step_speed", longint'(want.step_speed),
					longint'(out_ch.step_speed));
				check_field("total_distance", longint'(want.total_distance),
					longint'(out_ch.total_distance));
				check_field("last", longint'(want.last), longint'(out_ch.last));
				check_field("empty_res", longint'(want.empty_res),
					longint'(out_ch.empty_res));
				check_field("truncated", longint'(want.truncated),
					longint'(out_ch.truncated));
			end
		end
		out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// reset register values, tolerance edges, field extremes, inverted window
	task automatic test_default_registers();
		send_request(0, 0, 0);
		send_request(0, 0, jlsp_pkg::FIELD_W'(ONE));
		send_request(jlsp_pkg::FIELD_W'(ONE), 0, 0);
		send_request(-6554, 0, 0);
		send_request(-6555, 0, 0);
		send_request(6554, 0, 0);
		send_request(6555, 0, 0);
		send_request(24'sh800000, 0, 24'sh7FFFFF);
		send_request(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
		send_request(0, 24'sh7FFFFF, jlsp_pkg::FIELD_W'(5 * ONE));
		send_request(0, 24'sh800000, jlsp_pkg::FIELD_W'(-5 * ONE));
	endtask

	// zero jerk, full accel and step time: speed and distance saturate
	task automatic test_speed_saturation();
		write_registers(24'h000000, 24'h7FFFFF, 24'h00FFFF, 24'h000000);
		send_request(24'sh7FFFFE, 24'sh7FFFFF, 24'sh7FFFFF);
		send_request(24'sh800001, 24'sh800000, 24'sh800000);
	endtask

	// upper bits set in the data are masked off, leaving zero
	task automatic test_zero_registers();
		write_registers(24'h000000, 24'h800000, 24'h010000, 24'hFF0000);
		send_request(0, 0, jlsp_pkg::FIELD_W'(ONE));
		send_request(0, 0, 0);
	endtask

	task automatic test_register_extremes();
		write_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_request(0, 0, jlsp_pkg::FIELD_W'(ONE / 2));
		send_request(0, 0, 24'sh400000);
		send_request(24'sh7FFFFF, 0, 24'sh800000);
		send_request(jlsp_pkg::FIELD_W'(-5 * ONE), jlsp_pkg::FIELD_W'(ONE),
			jlsp_pkg::FIELD_W'(50 * ONE));
		write_registers(24'd655360, 24'd655360, 24'd1, 24'd0);
		send_request(0, 0, jlsp_pkg::FIELD_W'(ONE));
	endtask

	task automatic test_random_profiles(input int src_pct, input int sink_pct);
		logic signed [jlsp_pkg::FIELD_W-1:0] s0, a0, tgt;
		logic [jlsp_pkg::CFG_W-1:0]          jerk, accel, dt, tol;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		repeat (3) begin
			jerk  = jlsp_pkg::CFG_W'($urandom_range(65536, 24'hFFFFFF));
			accel = {1'($urandom), 23'($urandom_range(65536, 23'h7FFFFF))};
			dt    = {8'($urandom), 16'($urandom_range(655, 65535))};
			tol   = {8'($urandom), 16'($urandom)};
			write_registers(jerk, accel, dt, tol);
			repeat (30) begin
				s0 = jlsp_pkg::FIELD_W'($urandom);
				if ($urandom_range(3) == 0) begin
					a0  = jlsp_pkg::FIELD_W'($urandom);
					tgt = jlsp_pkg::FIELD_W'($urandom);
				end else begin
					a0  = jlsp_pkg::FIELD_W'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
					tgt = jlsp_pkg::FIELD_W'(clip(longint'(s0) +
						int'($urandom_range(0, 8 * ONE)) - 4 * ONE, jlsp_pkg::FIELD_W));
				end
				send_request(s0, a0, tgt);
			end
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= jlsp_pkg::REG_JERK_LIMIT;
		cfg_data           <= '0;
		in_ch.valid        <= 1'b0;
		in_ch.start_speed  <= '0;
		in_ch.start_accel  <= '0;
		in_ch.target_speed <= '0;
		error_count   = 0;
		src_idle_pct  = 15;
		sink_idle_pct = 62;
		jerk_reg = 24'd655360;
		alim_reg = 23'd655360;
		dt_reg   = 16'd1311;
		tol_reg  = 16'd6554;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_registers();
		test_speed_saturation();
		test_zero_registers();
		test_register_extremes();
		test_random_profiles(15, 62);
		test_random_profiles(62, 15);
		test_random_profiles(0, 0);

		drain_results();
		repeat (60) @(posedge clk);
		if (error_count == 0 && expected_steps.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule
